FILE: hw/rtl/s16lt_pkg.sv
// Shared types and constants for the 16-bit serial link transceiver.
package s16lt_pkg;

  // Tick counts are 16 bits wide
  localparam int unsigned TICK_W = 16;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TX_BIT   = 2'd0,
    REG_RX_START = 2'd1,
    REG_RX_BIT   = 2'd2,
    REG_RX_STOP  = 2'd3
  } cfg_reg_t;

  // Register reset values
  localparam logic [TICK_W-1:0] TX_BIT_RST   = 16'd610;
  localparam logic [TICK_W-1:0] RX_START_RST = 16'd250;
  localparam logic [TICK_W-1:0] RX_BIT_RST   = 16'd615;
  localparam logic [TICK_W-1:0] RX_STOP_RST  = 16'd625;

  // Frame phases; the unused code behaves as idle
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_TX_START = 3'd1,
    PH_TX_DATA  = 3'd2,
    PH_TX_STOP  = 3'd3,
    PH_RX_START = 3'd4,
    PH_RX_DATA  = 3'd5,
    PH_RX_STOP  = 3'd6
  } phase_t;

endpackage

FILE: hw/rtl/s16lt_item_if.sv
// Input tick channel: line level and send request.
interface s16lt_item_if #(
  parameter int unsigned DATA_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 line_in;
  logic                 send_request;
  logic [DATA_BITS-1:0] send_word;

  modport source (output valid, output line_in, output send_request, output send_word,
                  input ready);
  modport sink (input valid, input line_in, input send_request, input send_word,
                output ready);
endinterface

FILE: hw/rtl/s16lt_result_if.sv
// Result channel: line drive and receive status for one tick.
interface s16lt_result_if #(
  parameter int unsigned DATA_BITS = 16
);
  logic                 valid;
  logic                 ready;
  logic                 line_out;
  logic                 line_drive;
  logic [DATA_BITS-1:0] rx_word;
  logic                 rx_valid;
  logic                 frame_error;
  logic                 busy_res;
  logic                 tx_done;

  modport source (output valid, output line_out, output line_drive, output rx_word,
                  output rx_valid, output frame_error, output busy_res, output tx_done,
                  input ready);
  modport sink (input valid, input line_out, input line_drive, input rx_word,
                input rx_valid, input frame_error, input busy_res, input tx_done,
                output ready);
endinterface

FILE: hw/rtl/s16lt_cfg_if.sv
// Configuration write channel: register index and data.
interface s16lt_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/serial16_link_transceiver_unit.sv
// Half-duplex one-wire serial transceiver, start + DATA_BITS LSB first + stop.
// Every input transaction is one tick of link time: it carries the sampled line
// level and an optional send request, and produces exactly one result. A tick is
// taken every clock cycle while the skid register is empty; the frame state
// machine and its tick counter advance on each accepted tick, and the result
// lands in an output register backed by a skid register, so input ticks keep
// flowing while one result waits to be taken. Bit timing comes from four 16-bit
// tick-count registers written over the configuration channel (0: tx bit, 1: rx
// start delay, 2: rx bit, 3: rx stop delay); a value of zero acts as one tick.
// Write them only while the link is idle.
module serial16_link_transceiver_unit
  import s16lt_pkg::*;
#(
  parameter int unsigned DATA_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  s16lt_item_if.sink                items,
  s16lt_result_if.source            results,
  s16lt_cfg_if.sink                 cfg
);

  localparam int unsigned IDX_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DATA_BITS - 1);

  // Configuration registers
  logic [TICK_W-1:0] tx_bit_ticks;
  logic [TICK_W-1:0] rx_start_ticks;
  logic [TICK_W-1:0] rx_bit_ticks;
  logic [TICK_W-1:0] rx_stop_ticks;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_bit_ticks   <= TX_BIT_RST;
      rx_start_ticks <= RX_START_RST;
      rx_bit_ticks   <= RX_BIT_RST;
      rx_stop_ticks  <= RX_STOP_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_TX_BIT:   tx_bit_ticks   <= cfg.data;
        REG_RX_START: rx_start_ticks <= cfg.data;
        REG_RX_BIT:   rx_bit_ticks   <= cfg.data;
        REG_RX_STOP:  rx_stop_ticks  <= cfg.data;
        default:      tx_bit_ticks   <= tx_bit_ticks;
      endcase
    end
  end

  // Frame state
  phase_t               phase,        phase_next;
  logic [TICK_W-1:0]    tick_count,   tick_count_next;
  logic [IDX_W-1:0]     bit_index,    bit_index_next;
  logic [DATA_BITS-1:0] rx_shift,     rx_shift_next;
  logic [DATA_BITS-1:0] tx_shift,     tx_shift_next;
  logic                 start_sample, start_sample_next;
  logic                 error_flag,   error_flag_next;
  logic                 drive_level,  drive_level_next;

  // Handshake
  logic item_acc;
  logic out_valid, skid_valid;
  logic out_take;

  assign item_acc = items.valid & items.ready;

  // Period select and tick counter
  logic [TICK_W-1:0] period;
  logic [TICK_W-1:0] tick_inc;
  logic              period_done;

  always_comb begin
    unique case (phase)
      PH_TX_START, PH_TX_DATA, PH_TX_STOP: period = tx_bit_ticks;
      PH_RX_START:                         period = rx_start_ticks;
      PH_RX_DATA:                          period = rx_bit_ticks;
      PH_RX_STOP:                          period = rx_stop_ticks;
      default:                             period = tx_bit_ticks;
    endcase
  end

  assign tick_inc    = tick_count + TICK_W'(1);
  assign period_done = (tick_inc >= period);

  // Next-state logic for one tick
  always_comb begin
    phase_next        = phase;
    tick_count_next   = period_done ? '0 : tick_inc;
    bit_index_next    = bit_index;
    rx_shift_next     = rx_shift;
    tx_shift_next     = tx_shift;
    start_sample_next = start_sample;
    error_flag_next   = error_flag;
    drive_level_next  = drive_level;
    unique case (phase)
      PH_TX_START: begin
        if (period_done) begin
          drive_level_next = tx_shift[0];
          tx_shift_next    = tx_shift >> 1;
          bit_index_next   = '0;
          phase_next       = PH_TX_DATA;
        end
      end
      PH_TX_DATA: begin
        if (period_done) begin
          if (bit_index == LAST_IDX) begin
            drive_level_next = 1'b1;
            phase_next       = PH_TX_STOP;
          end else begin
            bit_index_next   = bit_index + IDX_W'(1);
            drive_level_next = tx_shift[0];
            tx_shift_next    = tx_shift >> 1;
          end
        end
      end
      PH_TX_STOP: begin
        if (period_done) begin
          phase_next = PH_IDLE;
        end
      end
      PH_RX_START: begin
        if (period_done) begin
          start_sample_next = items.line_in;
          bit_index_next    = '0;
          phase_next        = PH_RX_DATA;
        end
      end
      PH_RX_DATA: begin
        if (period_done) begin
          rx_shift_next = (rx_shift >> 1)
                        | (DATA_BITS'(items.line_in) << (DATA_BITS - 1));
          if (bit_index == LAST_IDX) begin
            phase_next = PH_RX_STOP;
          end else begin
            bit_index_next = bit_index + IDX_W'(1);
          end
        end
      end
      PH_RX_STOP: begin
        if (period_done) begin
          error_flag_next = start_sample | ~items.line_in;
          phase_next      = PH_IDLE;
        end
      end
      default: begin
        // Idle: send request wins over a low line
        phase_next      = PH_IDLE;
        tick_count_next = '0;
        if (items.send_request) begin
          tx_shift_next    = items.send_word;
          drive_level_next = 1'b0;
          bit_index_next   = '0;
          phase_next       = PH_TX_START;
        end else if (!items.line_in) begin
          rx_shift_next  = '0;
          bit_index_next = '0;
          phase_next     = PH_RX_START;
        end
      end
    endcase
  end

  // Result fields for this tick
  logic res_line_drive, res_rx_valid, res_busy, res_tx_done;

  always_comb begin
    res_line_drive = (phase_next == PH_TX_START) || (phase_next == PH_TX_DATA)
                  || (phase_next == PH_TX_STOP);
    res_busy       = (phase_next != PH_IDLE);
    res_rx_valid   = (phase == PH_RX_STOP) && period_done;
    res_tx_done    = (phase == PH_TX_STOP) && period_done;
  end

  // State registers advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      tick_count   <= '0;
      bit_index    <= '0;
      rx_shift     <= '0;
      tx_shift     <= '0;
      start_sample <= 1'b0;
      error_flag   <= 1'b0;
      drive_level  <= 1'b1;
    end else if (item_acc) begin
      phase        <= phase_next;
      tick_count   <= tick_count_next;
      bit_index    <= bit_index_next;
      rx_shift     <= rx_shift_next;
      tx_shift     <= tx_shift_next;
      start_sample <= start_sample_next;
      error_flag   <= error_flag_next;
      drive_level  <= drive_level_next;
    end
  end

  // Output register plus skid register
  logic                 out_line_out, out_line_drive, out_rx_valid;
  logic                 out_frame_error, out_busy, out_tx_done;
  logic [DATA_BITS-1:0] out_rx_word;
  logic                 skid_line_out, skid_line_drive, skid_rx_valid;
  logic                 skid_frame_error, skid_busy, skid_tx_done;
  logic [DATA_BITS-1:0] skid_rx_word;
  logic                 load_out, load_skid;

  assign items.ready = ~skid_valid;
  assign out_take    = out_valid & results.ready;
  assign load_out    = item_acc & (~out_valid | out_take);
  assign load_skid   = item_acc & out_valid & ~out_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_take && skid_valid) begin
        out_valid <= 1'b1;
      end else if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      if (load_skid) begin
        skid_valid <= 1'b1;
      end else if (out_take) begin
        skid_valid <= 1'b0;
      end
    end
  end

  // Skid only fills when it is empty, so it never competes with out_take
  always_ff @(posedge clk) begin
    if (load_skid) begin
      skid_line_out    <= drive_level_next;
      skid_line_drive  <= res_line_drive;
      skid_rx_word     <= rx_shift_next;
      skid_rx_valid    <= res_rx_valid;
      skid_frame_error <= error_flag_next;
      skid_busy        <= res_busy;
      skid_tx_done     <= res_tx_done;
    end
  end

  always_ff @(posedge clk) begin
    if (out_take && skid_valid) begin
      out_line_out    <= skid_line_out;
      out_line_drive  <= skid_line_drive;
      out_rx_word     <= skid_rx_word;
      out_rx_valid    <= skid_rx_valid;
      out_frame_error <= skid_frame_error;
      out_busy        <= skid_busy;
      out_tx_done     <= skid_tx_done;
    end else if (load_out) begin
      out_line_out    <= drive_level_next;
      out_line_drive  <= res_line_drive;
      out_rx_word     <= rx_shift_next;
      out_rx_valid    <= res_rx_valid;
      out_frame_error <= error_flag_next;
      out_busy        <= res_busy;
      out_tx_done     <= res_tx_done;
    end
  end

  assign results.valid       = out_valid;
  assign results.line_out    = out_line_out;
  assign results.line_drive  = out_line_drive;
  assign results.rx_word     = out_rx_word;
  assign results.rx_valid    = out_rx_valid;
  assign results.frame_error = out_frame_error;
  assign results.busy_res    = out_busy;
  assign results.tx_done     = out_tx_done;

endmodule

FILE: dv/tb.sv
// Testbench for the 16-bit serial link transceiver: tick-level prediction and checking.
`timescale 1ns / 1ps

module tb
  import s16lt_pkg::*;
();

  localparam int unsigned DATA_BITS     = 16;
  localparam int          SETTLE_CYCLES = 4;
  localparam int          MAX_REPORTS   = 200;

  // One result transaction as seen on the result channel
  typedef struct {
    logic                 line_out;
    logic                 line_drive;
    logic [DATA_BITS-1:0] rx_word;
    logic                 rx_valid;
    logic                 frame_error;
    logic                 busy_res;
    logic                 tx_done;
  } link_tick_t;

  logic clk;
  logic rst;

  s16lt_item_if #(.DATA_BITS(DATA_BITS))   item_ch ();
  s16lt_result_if #(.DATA_BITS(DATA_BITS)) result_ch ();
  s16lt_cfg_if                             cfg_ch ();

  serial16_link_transceiver_unit #(
    .DATA_BITS(DATA_BITS)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .items  (item_ch),
    .results(result_ch),
    .cfg    (cfg_ch)
  );

  // Predicted link state and bit timing
  phase_t               lk_phase;
  logic [15:0]          lk_count;
  logic [4:0]           lk_bit;
  logic [DATA_BITS-1:0] lk_rx_shift;
  logic [DATA_BITS-1:0] lk_tx_shift;
  logic                 lk_start_lvl;
  logic                 lk_err;
  logic                 lk_level;
  logic [15:0]          per_tx_bit;
  logic [15:0]          per_rx_start;
  logic [15:0]          per_rx_bit;
  logic [15:0]          per_rx_stop;

  link_tick_t link_expect_q[$];
  int         mismatch_count;
  int         ticks_sent;
  bit         tick_gaps_on;
  bit         result_stalls_on;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #(64'd20_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string what, input longint got, input longint wanted);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t mismatch %s: got %0h, expected %0h", $time, what, got, wanted);
    end
    mismatch_count++;
  endtask

  // Counter advance; true when the period has run out (zero behaves as one)
  function automatic logic period_elapsed(input logic [15:0] period);
    lk_count = lk_count + 16'd1;
    if (lk_count >= period) begin
      lk_count = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // True when the coming tick is the one that samples the line
  function automatic logic sample_due(input logic [15:0] period);
    logic [15:0] next_count;
    next_count = lk_count + 16'd1;
    return next_count >= period;
  endfunction

  // Advance the link by one tick and queue the result it must show
  function automatic void step_link(input logic ln, input logic rq, input logic [15:0] wd);
    link_tick_t r;
    logic       got_frame;
    logic       sent_frame;
    got_frame  = 1'b0;
    sent_frame = 1'b0;
    case (lk_phase)
      PH_TX_START: begin
        if (period_elapsed(per_tx_bit)) begin
          lk_level    = lk_tx_shift[0];
          lk_tx_shift = lk_tx_shift >> 1;
          lk_bit      = '0;
          lk_phase    = PH_TX_DATA;
        end
      end
      PH_TX_DATA: begin
        if (period_elapsed(per_tx_bit)) begin
          if (lk_bit >= 5'(DATA_BITS - 1)) begin
            lk_level = 1'b1;
            lk_phase = PH_TX_STOP;
          end else begin
            lk_bit      = lk_bit + 5'd1;
            lk_level    = lk_tx_shift[0];
            lk_tx_shift = lk_tx_shift >> 1;
          end
        end
      end
      PH_TX_STOP: begin
        if (period_elapsed(per_tx_bit)) begin
          sent_frame = 1'b1;
          lk_phase   = PH_IDLE;
        end
      end
      PH_RX_START: begin
        if (period_elapsed(per_rx_start)) begin
          lk_start_lvl = ln;
          lk_bit       = '0;
          lk_phase     = PH_RX_DATA;
        end
      end
      PH_RX_DATA: begin
        if (period_elapsed(per_rx_bit)) begin
          lk_rx_shift = {ln, lk_rx_shift[DATA_BITS-1:1]};
          if (lk_bit >= 5'(DATA_BITS - 1)) begin
            lk_phase = PH_RX_STOP;
          end else begin
            lk_bit = lk_bit + 5'd1;
          end
        end
      end
      PH_RX_STOP: begin
        if (period_elapsed(per_rx_stop)) begin
          lk_err    = lk_start_lvl | ~ln;
          got_frame = 1'b1;
          lk_phase  = PH_IDLE;
        end
      end
      default: begin
        // Idle: a send request wins over a low line
        lk_phase = PH_IDLE;
        lk_count = '0;
        if (rq) begin
          lk_tx_shift = wd;
          lk_level    = 1'b0;
          lk_bit      = '0;
          lk_phase    = PH_TX_START;
        end else if (!ln) begin
          lk_rx_shift = '0;
          lk_bit      = '0;
          lk_phase    = PH_RX_START;
        end
      end
    endcase
    r.line_out    = lk_level;
    r.line_drive  = (lk_phase == PH_TX_START) || (lk_phase == PH_TX_DATA) ||
                    (lk_phase == PH_TX_STOP);
    r.rx_word     = lk_rx_shift;
    r.rx_valid    = got_frame;
    r.frame_error = lk_err;
    r.busy_res    = (lk_phase != PH_IDLE);
    r.tx_done     = sent_frame;
    link_expect_q.push_back(r);
  endfunction

  // Send one tick transaction; the prediction runs at acceptance
  task automatic send_tick(input logic ln, input logic rq, input logic [15:0] wd);
    int gap;
    gap = tick_gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid        <= 1'b1;
    item_ch.line_in      <= ln;
    item_ch.send_request <= rq;
    item_ch.send_word    <= wd;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    step_link(ln, rq, wd);
    ticks_sent++;
  endtask

  // Hold off the sender until every predicted result has been taken
  task automatic wait_drained();
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (link_expect_q.size() != 0) @(posedge clk);
  endtask

  // Idle-line ticks until the current frame has finished
  task automatic run_to_idle();
    while (lk_phase != PH_IDLE) send_tick(1'b1, 1'b0, 16'($urandom()));
  endtask

  task automatic settle();
    run_to_idle();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      REG_TX_BIT:   per_tx_bit   = val;
      REG_RX_START: per_rx_start = val;
      REG_RX_BIT:   per_rx_bit   = val;
      default:      per_rx_stop  = val;
    endcase
  endtask

  // Writes all four periods back to back; call only with the link settled
  task automatic program_regs(input logic [15:0] tx_v, input logic [15:0] rs_v,
                              input logic [15:0] rb_v, input logic [15:0] rp_v);
    write_reg(REG_TX_BIT, tx_v);
    write_reg(REG_RX_START, rs_v);
    write_reg(REG_RX_BIT, rb_v);
    write_reg(REG_RX_STOP, rp_v);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drive one received frame onto the line, timed from the predicted sampling;
  // with noise the line toggles freely between sample points
  task automatic rx_frame(input logic [15:0] wd, input logic bad_start, input logic bad_stop,
                          input logic noisy);
    logic slot;
    logic due;
    logic lvl;
    run_to_idle();
    send_tick(1'b0, 1'b0, 16'($urandom()));
    while (lk_phase != PH_IDLE) begin
      case (lk_phase)
        PH_RX_START: begin
          slot = bad_start;
          due  = sample_due(per_rx_start);
        end
        PH_RX_DATA: begin
          slot = wd[lk_bit[3:0]];
          due  = sample_due(per_rx_bit);
        end
        default: begin
          slot = ~bad_stop;
          due  = sample_due(per_rx_stop);
        end
      endcase
      lvl = (noisy && !due) ? 1'($urandom_range(0, 1)) : slot;
      // requests during reception must be ignored
      send_tick(lvl, 1'($urandom_range(0, 1)), 16'($urandom()));
    end
  endtask

  // Transmit one word; line and further requests are junk while sending
  task automatic tx_frame(input logic [15:0] wd, input logic first_line);
    run_to_idle();
    send_tick(first_line, 1'b1, wd);
    while (lk_phase != PH_IDLE) begin
      send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 16'($urandom()));
    end
  endtask

  // Random ticks, line mostly high, the odd request
  task automatic noise_burst(input int n);
    repeat (n) begin
      send_tick(1'($urandom_range(0, 3) != 0), 1'($urandom_range(0, 7) == 0),
                16'($urandom()));
    end
  endtask

  // Idle ticks straight after reset: line released and high, nothing received
  task automatic test_reset_periods();
    tick_gaps_on     = 1'b0;
    result_stalls_on = 1'b0;
    repeat (20) send_tick(1'b1, 1'b0, 16'($urandom()));
    settle();
  endtask

  // Zero periods behave as one tick; word extremes and framing errors
  task automatic test_zero_periods();
    tick_gaps_on     = 1'b1;
    result_stalls_on = 1'b1;
    program_regs(16'd0, 16'd0, 16'd0, 16'd0);
    rx_frame(16'h0000, 1'b0, 1'b0, 1'b0);
    rx_frame(16'hFFFF, 1'b0, 1'b0, 1'b0);
    rx_frame(16'h1234, 1'b1, 1'b0, 1'b0);
    rx_frame(16'h8001, 1'b0, 1'b1, 1'b0);
    rx_frame(16'h7FFE, 1'b1, 1'b1, 1'b0);
    rx_frame(16'h5A5A, 1'b0, 1'b0, 1'b0);
    tx_frame(16'h0000, 1'b1);
    tx_frame(16'hFFFF, 1'b1);
    // request and low line together: the request wins
    tx_frame(16'hC001, 1'b0);
    settle();
  endtask

  // Single-tick periods, then uneven small ones
  task automatic test_short_periods();
    tick_gaps_on     = 1'b1;
    result_stalls_on = 1'b1;
    program_regs(16'd1, 16'd1, 16'd1, 16'd1);
    rx_frame(16'h3C96, 1'b0, 1'b0, 1'b1);
    tx_frame(16'h6B2D, 1'b1);
    settle();
    program_regs(16'd1, 16'd3, 16'd2, 16'd4);
    rx_frame(16'hE817, 1'b0, 1'b0, 1'b1);
    rx_frame(16'h0F0F, 1'b0, 1'b1, 1'b1);
    tx_frame(16'h9ABC, 1'b0);
    settle();
  endtask

  // Longer start and stop delays; largest tx period written but not run
  task automatic test_long_delays();
    tick_gaps_on     = 1'b0;
    result_stalls_on = 1'b0;
    program_regs(16'hFFFF, 16'd40, 16'd2, 16'd40);
    rx_frame(16'($urandom()), 1'b0, 1'b0, 1'b1);
    settle();
  endtask

  // Mostly well-formed frames with random content, some noise and broken frames
  task automatic test_random_traffic();
    int ph;
    int stop_at;
    for (ph = 0; ph < 5; ph++) begin
      settle();
      if (ph == 3) begin
        program_regs(16'($urandom_range(6, 12)), 16'($urandom_range(6, 12)),
                     16'($urandom_range(6, 12)), 16'($urandom_range(6, 12)));
      end else begin
        program_regs(16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)),
                     16'($urandom_range(0, 5)), 16'($urandom_range(0, 5)));
      end
      tick_gaps_on     = (ph != 1);
      result_stalls_on = (ph != 2);
      stop_at = ticks_sent + 80;
      while (ticks_sent < stop_at) begin
        if ($urandom_range(0, 19) == 0) wait_drained();
        case ($urandom_range(0, 7))
          0, 1, 2, 3: begin
            rx_frame(16'($urandom()), 1'($urandom_range(0, 7) == 0),
                     1'($urandom_range(0, 7) == 0), 1'($urandom_range(0, 1)));
          end
          4, 5: begin
            tx_frame(16'($urandom()), 1'($urandom_range(0, 1)));
          end
          default: begin
            noise_burst($urandom_range(1, 8));
          end
        endcase
        repeat ($urandom_range(0, 3)) send_tick(1'b1, 1'b0, 16'($urandom()));
      end
    end
    settle();
  endtask

  // Result side: ready held off for a random number of cycles per transaction
  initial begin
    int stall;
    forever begin
      stall = result_stalls_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(result_ch.valid && !rst)) @(posedge clk);
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    link_tick_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (link_expect_q.size() == 0) begin
        report_mismatch("result with nothing expected", 0, 0);
      end else begin
        want = link_expect_q.pop_front();
        if (result_ch.line_out !== want.line_out)
          report_mismatch("line_out", result_ch.line_out, want.line_out);
        if (result_ch.line_drive !== want.line_drive)
          report_mismatch("line_drive", result_ch.line_drive, want.line_drive);
        if (result_ch.rx_word !== want.rx_word)
          report_mismatch("rx_word", result_ch.rx_word, want.rx_word);
        if (result_ch.rx_valid !== want.rx_valid)
          report_mismatch("rx_valid", result_ch.rx_valid, want.rx_valid);
        if (result_ch.frame_error !== want.frame_error)
          report_mismatch("frame_error", result_ch.frame_error, want.frame_error);
        if (result_ch.busy_res !== want.busy_res)
          report_mismatch("busy_res", result_ch.busy_res, want.busy_res);
        if (result_ch.tx_done !== want.tx_done)
          report_mismatch("tx_done", result_ch.tx_done, want.tx_done);
      end
    end
  end

  // Main sequence
  initial begin
    mismatch_count   = 0;
    ticks_sent       = 0;
    tick_gaps_on     = 1'b0;
    result_stalls_on = 1'b0;
    lk_phase         = PH_IDLE;
    lk_count         = '0;
    lk_bit           = '0;
    lk_rx_shift      = '0;
    lk_tx_shift      = '0;
    lk_start_lvl     = 1'b0;
    lk_err           = 1'b0;
    lk_level         = 1'b1;
    per_tx_bit       = TX_BIT_RST;
    per_rx_start     = RX_START_RST;
    per_rx_bit       = RX_BIT_RST;
    per_rx_stop      = RX_STOP_RST;

    rst                  <= 1'b1;
    item_ch.valid        <= 1'b0;
    item_ch.line_in      <= 1'b1;
    item_ch.send_request <= 1'b0;
    item_ch.send_word    <= '0;
    cfg_ch.valid         <= 1'b0;
    cfg_ch.index         <= REG_TX_BIT;
    cfg_ch.data          <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_periods();
    test_zero_periods();
    test_short_periods();
    test_long_delays();
    test_random_traffic();

    // settle() has drained every prediction; give stray results time to show
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/s16lt_pkg.sv
hw/rtl/s16lt_item_if.sv
hw/rtl/s16lt_result_if.sv
hw/rtl/s16lt_cfg_if.sv
hw/rtl/serial16_link_transceiver_unit.sv
dv/tb.sv
